// ===== rtl/core/lbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbpc_pkg
// shared types and constants of the led blink pattern controller
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int PIN_W      = 6;
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 16;
    localparam int FLIP_W     = 17;
    localparam int OUT_SLOT_W = 2;
    localparam int OUT_MASK_W = 3;

    localparam logic [OUT_SLOT_W-1:0] NO_SLOT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } lbpc_state_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_LOAD,
        OP_STOP
    } lbpc_op_t;

    typedef struct packed {
        logic busy;
        logic capture;
        logic tick_wr;
        logic scan;
        logic cmd_wr;
        logic finish;
    } lbpc_ctrl_t;

endpackage

// ===== rtl/core/lbpc_slot_unit.sv =====
// ----------------------------------------------------------------------------
// lbpc_slot_unit
// shared per-slot update: tick countdown, blink load or stop for one slot
// ----------------------------------------------------------------------------
module lbpc_slot_unit #(
    parameter int INTERVAL_BITS = 16
) (
    input  lbpc_pkg::lbpc_op_t           op,
    input  logic                         cur_allocated,
    input  logic                         cur_running,
    input  logic                         cur_lit,
    input  logic [lbpc_pkg::PIN_W-1:0]   cur_pin,
    input  logic [INTERVAL_BITS-1:0]     cur_interval,
    input  logic [INTERVAL_BITS-1:0]     cur_pause,
    input  logic [lbpc_pkg::CNT_W-1:0]   cur_count,
    input  logic                         cur_repeat,
    input  logic [lbpc_pkg::FLIP_W-1:0]  cur_flips,
    input  logic [INTERVAL_BITS-1:0]     cur_remaining,
    input  logic [lbpc_pkg::PIN_W-1:0]   cmd_pin,
    input  logic [lbpc_pkg::FIELD_W-1:0] cmd_interval,
    input  logic [lbpc_pkg::FIELD_W-1:0] cmd_pause,
    input  logic [lbpc_pkg::CNT_W-1:0]   cmd_count,
    input  logic                         cmd_repeat,
    output logic                         nxt_allocated,
    output logic                         nxt_running,
    output logic                         nxt_lit,
    output logic [lbpc_pkg::PIN_W-1:0]   nxt_pin,
    output logic [INTERVAL_BITS-1:0]     nxt_interval,
    output logic [INTERVAL_BITS-1:0]     nxt_pause,
    output logic [lbpc_pkg::CNT_W-1:0]   nxt_count,
    output logic                         nxt_repeat,
    output logic [lbpc_pkg::FLIP_W-1:0]  nxt_flips,
    output logic [INTERVAL_BITS-1:0]     nxt_remaining
);
    import lbpc_pkg::*;

    localparam int WB = (INTERVAL_BITS > FIELD_W) ? INTERVAL_BITS : FIELD_W;

    // saturate to the interval width, zero counts as one tick
    function automatic logic [INTERVAL_BITS-1:0] fit(input logic [FIELD_W-1:0] v);
        logic [WB-1:0] w;
        logic [WB-1:0] maxv;
        begin
            w    = WB'(v);
            maxv = WB'({INTERVAL_BITS{1'b1}});
            if (w > maxv)
            begin
                w = maxv;
            end
            if (w == '0)
            begin
                w = WB'(1);
            end
            fit = w[INTERVAL_BITS-1:0];
        end
    endfunction

    logic [INTERVAL_BITS-1:0] rem_dec;
    logic [FLIP_W-1:0]        flips_inc;
    logic [FLIP_W-1:0]        flips_end;
    logic [INTERVAL_BITS-1:0] fit_int;

    assign rem_dec   = (cur_remaining == '0) ? '0 : cur_remaining - INTERVAL_BITS'(1);
    assign flips_inc = cur_flips + FLIP_W'(1);
    assign flips_end = {cur_count, 1'b0};
    assign fit_int   = fit(cmd_interval);

    always_comb
    begin
        nxt_allocated = cur_allocated;
        nxt_running   = cur_running;
        nxt_lit       = cur_lit;
        nxt_pin       = cur_pin;
        nxt_interval  = cur_interval;
        nxt_pause     = cur_pause;
        nxt_count     = cur_count;
        nxt_repeat    = cur_repeat;
        nxt_flips     = cur_flips;
        nxt_remaining = cur_remaining;
        case (op)
            OP_TICK:
            begin
                if (cur_running)
                begin
                    nxt_remaining = rem_dec;
                    if (rem_dec == '0)
                    begin
                        nxt_lit       = ~cur_lit;
                        nxt_remaining = cur_interval;
                        if (cur_count != '0)
                        begin
                            nxt_flips = flips_inc;
                            // burst finished after twice the count of flips
                            if (flips_inc >= flips_end)
                            begin
                                if (cur_repeat)
                                begin
                                    nxt_flips     = '0;
                                    nxt_remaining = cur_pause;
                                end
                                else
                                begin
                                    nxt_lit       = 1'b0;
                                    nxt_running   = 1'b0;
                                    nxt_remaining = rem_dec;
                                end
                            end
                        end
                    end
                end
            end
            OP_LOAD:
            begin
                nxt_allocated = 1'b1;
                nxt_running   = 1'b1;
                nxt_lit       = 1'b0;
                nxt_pin       = cmd_pin;
                nxt_interval  = fit_int;
                nxt_pause     = fit(cmd_pause);
                nxt_count     = cmd_count;
                nxt_repeat    = cmd_repeat;
                nxt_flips     = '0;
                nxt_remaining = fit_int;
            end
            OP_STOP:
            begin
                if (cur_allocated)
                begin
                    nxt_running = 1'b0;
                    nxt_lit     = 1'b0;
                end
            end
            default:
            begin
                nxt_running = cur_running;
            end
        endcase
    end

endmodule

// ===== rtl/core/lbpc_seq.sv =====
// ----------------------------------------------------------------------------
// lbpc_seq
// sequencer: walks the slots one per cycle for ticks and command searches
// ----------------------------------------------------------------------------
module lbpc_seq #(
    parameter int SLOT_COUNT = 3,
    parameter int SLOT_W     = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 operation,
    input  logic                 hit,
    output lbpc_pkg::lbpc_ctrl_t ctrl,
    output logic [SLOT_W-1:0]    idx
);
    import lbpc_pkg::*;

    lbpc_state_t       state_reg;
    lbpc_state_t       state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              last;

    assign last = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign idx  = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = operation ? ST_SCAN : ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_SCAN:
            begin
                // first slot holding the pin or never used wins
                if (hit)
                begin
                    state_next = ST_APPLY;
                end
                else if (last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_APPLY:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.capture = start;
            end
            ST_TICK:
            begin
                ctrl.busy    = 1'b1;
                ctrl.tick_wr = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.busy = 1'b1;
                ctrl.scan = 1'b1;
            end
            ST_APPLY:
            begin
                ctrl.busy   = 1'b1;
                ctrl.cmd_wr = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.busy   = 1'b1;
                ctrl.finish = 1'b1;
            end
            default:
            begin
                ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/led_blink_pattern_controller_unit.sv =====
// ----------------------------------------------------------------------------
// led_blink_pattern_controller_unit
// led channel slots driven by millisecond ticks and blink/stop commands
// ----------------------------------------------------------------------------
// tick item: every slot is updated in turn, one slot per cycle, then the result strobe
// command item: search one slot a cycle; a matching slot then gets one update
// a new item is taken only while idle, once the previous item has finished; busy
// is high from the item's first slot step through its result strobe
// done is high for one cycle and cannot be stalled by the receiver
// reset clears all slots to unused, stopped and dark
module led_blink_pattern_controller_unit #(
    parameter int SLOT_COUNT    = 3,
    parameter int INTERVAL_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 operation,
    input  logic [lbpc_pkg::PIN_W-1:0]           pin,
    input  logic                                 stop_request,
    input  logic [lbpc_pkg::FIELD_W-1:0]         blink_interval,
    input  logic [lbpc_pkg::FIELD_W-1:0]         pause_interval,
    input  logic [lbpc_pkg::CNT_W-1:0]           blink_count,
    input  logic                                 repeat_burst,
    output logic                                 done,
    output logic                                 accepted,
    output logic [lbpc_pkg::OUT_SLOT_W-1:0]      slot_used,
    output logic [lbpc_pkg::OUT_MASK_W-1:0]      led_levels,
    output logic [lbpc_pkg::OUT_MASK_W-1:0]      running_mask
);
    import lbpc_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    lbpc_ctrl_t        ctrl;
    logic [SLOT_W-1:0] idx;
    logic              hit;
    logic              slot_we;
    lbpc_op_t          op;

    // captured item
    logic                 op_reg;
    logic [PIN_W-1:0]     pin_reg;
    logic                 stop_reg;
    logic [FIELD_W-1:0]   bint_reg;
    logic [FIELD_W-1:0]   pint_reg;
    logic [CNT_W-1:0]     bcnt_reg;
    logic                 rep_reg;

    // slot storage
    logic [SLOT_COUNT-1:0]    alloc_reg;
    logic [SLOT_COUNT-1:0]    running_reg;
    logic [SLOT_COUNT-1:0]    lit_reg;
    logic [SLOT_COUNT-1:0]    repeat_reg;
    logic [PIN_W-1:0]         pin_mem_reg      [SLOT_COUNT];
    logic [INTERVAL_BITS-1:0] interval_mem_reg [SLOT_COUNT];
    logic [INTERVAL_BITS-1:0] pause_mem_reg    [SLOT_COUNT];
    logic [CNT_W-1:0]         count_mem_reg    [SLOT_COUNT];
    logic [FLIP_W-1:0]        flips_mem_reg    [SLOT_COUNT];
    logic [INTERVAL_BITS-1:0] remain_mem_reg   [SLOT_COUNT];

    // result
    logic                  acc_reg;
    logic [OUT_SLOT_W-1:0] used_reg;

    // slot unit outputs
    logic                     n_alloc;
    logic                     n_running;
    logic                     n_lit;
    logic [PIN_W-1:0]         n_pin;
    logic [INTERVAL_BITS-1:0] n_interval;
    logic [INTERVAL_BITS-1:0] n_pause;
    logic [CNT_W-1:0]         n_count;
    logic                     n_repeat;
    logic [FLIP_W-1:0]        n_flips;
    logic [INTERVAL_BITS-1:0] n_remain;

    logic [SLOT_W+OUT_SLOT_W-1:0]     idx_ext;
    logic [SLOT_COUNT+OUT_MASK_W-1:0] lit_ext;
    logic [SLOT_COUNT+OUT_MASK_W-1:0] run_ext;

    lbpc_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .hit       (hit),
        .ctrl      (ctrl),
        .idx       (idx)
    );

    assign hit = (pin_mem_reg[idx] == pin_reg) || !alloc_reg[idx];

    always_comb
    begin
        if (!op_reg)
        begin
            op = OP_TICK;
        end
        else if (stop_reg)
        begin
            op = OP_STOP;
        end
        else
        begin
            op = OP_LOAD;
        end
    end

    lbpc_slot_unit #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_slot_unit (
        .op            (op),
        .cur_allocated (alloc_reg[idx]),
        .cur_running   (running_reg[idx]),
        .cur_lit       (lit_reg[idx]),
        .cur_pin       (pin_mem_reg[idx]),
        .cur_interval  (interval_mem_reg[idx]),
        .cur_pause     (pause_mem_reg[idx]),
        .cur_count     (count_mem_reg[idx]),
        .cur_repeat    (repeat_reg[idx]),
        .cur_flips     (flips_mem_reg[idx]),
        .cur_remaining (remain_mem_reg[idx]),
        .cmd_pin       (pin_reg),
        .cmd_interval  (bint_reg),
        .cmd_pause     (pint_reg),
        .cmd_count     (bcnt_reg),
        .cmd_repeat    (rep_reg),
        .nxt_allocated (n_alloc),
        .nxt_running   (n_running),
        .nxt_lit       (n_lit),
        .nxt_pin       (n_pin),
        .nxt_interval  (n_interval),
        .nxt_pause     (n_pause),
        .nxt_count     (n_count),
        .nxt_repeat    (n_repeat),
        .nxt_flips     (n_flips),
        .nxt_remaining (n_remain)
    );

    assign slot_we = ctrl.tick_wr | ctrl.cmd_wr;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            op_reg   <= operation;
            pin_reg  <= pin;
            stop_reg <= stop_request;
            bint_reg <= blink_interval;
            pint_reg <= pause_interval;
            bcnt_reg <= blink_count;
            rep_reg  <= repeat_burst;
        end
        if (slot_we)
        begin
            pin_mem_reg[idx]      <= n_pin;
            interval_mem_reg[idx] <= n_interval;
            pause_mem_reg[idx]    <= n_pause;
            count_mem_reg[idx]    <= n_count;
            flips_mem_reg[idx]    <= n_flips;
            remain_mem_reg[idx]   <= n_remain;
            repeat_reg[idx]       <= n_repeat;
        end
    end

    assign idx_ext = {{OUT_SLOT_W{1'b0}}, idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg   <= '0;
            running_reg <= '0;
            lit_reg     <= '0;
            acc_reg     <= 1'b0;
            used_reg    <= NO_SLOT;
        end
        else
        begin
            if (slot_we)
            begin
                alloc_reg[idx]   <= n_alloc;
                running_reg[idx] <= n_running;
                lit_reg[idx]     <= n_lit;
            end
            if (ctrl.capture)
            begin
                // ticks are always accepted, commands only once a slot is found
                acc_reg  <= ~operation;
                used_reg <= NO_SLOT;
            end
            else if (ctrl.scan && hit)
            begin
                acc_reg  <= 1'b1;
                used_reg <= idx_ext[OUT_SLOT_W-1:0];
            end
        end
    end

    assign lit_ext = {{OUT_MASK_W{1'b0}}, lit_reg};
    assign run_ext = {{OUT_MASK_W{1'b0}}, running_reg};

    assign busy         = ctrl.busy;
    assign done         = ctrl.finish;
    assign accepted     = acc_reg;
    assign slot_used    = used_reg;
    assign led_levels   = lit_ext[OUT_MASK_W-1:0];
    assign running_mask = run_ext[OUT_MASK_W-1:0];

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks led_blink_pattern_controller_unit against a cycle-free model of the
// slot table; every command and tick item is predicted and each result strobe
// is compared field by field, in order, with the oldest prediction
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lbpc_pkg::*;

    localparam int NUM_SLOTS     = 3;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        lbpc_op_t            kind;
        logic [PIN_W-1:0]    pin;
        logic [FIELD_W-1:0]  interval;
        logic [FIELD_W-1:0]  pause;
        logic [CNT_W-1:0]    count;
        logic                rep;
    } led_cmd_t;

    typedef struct {
        logic                   accepted;
        logic [OUT_SLOT_W-1:0]  slot_used;
        logic [OUT_MASK_W-1:0]  led_levels;
        logic [OUT_MASK_W-1:0]  running_mask;
    } led_status_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   operation;
    logic [PIN_W-1:0]       pin;
    logic                   stop_request;
    logic [FIELD_W-1:0]     blink_interval;
    logic [FIELD_W-1:0]     pause_interval;
    logic [CNT_W-1:0]       blink_count;
    logic                   repeat_burst;
    logic                   done;
    logic                   accepted;
    logic [OUT_SLOT_W-1:0]  slot_used;
    logic [OUT_MASK_W-1:0]  led_levels;
    logic [OUT_MASK_W-1:0]  running_mask;

    // slot table as the block should hold it
    logic [PIN_W-1:0]    led_pin       [NUM_SLOTS];
    logic                led_allocated [NUM_SLOTS];
    logic                led_running   [NUM_SLOTS];
    logic                led_lit       [NUM_SLOTS];
    logic [FIELD_W-1:0]  led_interval  [NUM_SLOTS];
    logic [FIELD_W-1:0]  led_pause     [NUM_SLOTS];
    logic [CNT_W-1:0]    led_count     [NUM_SLOTS];
    logic                led_repeat    [NUM_SLOTS];
    logic [FLIP_W-1:0]   led_flips     [NUM_SLOTS];
    logic [FIELD_W-1:0]  led_remaining [NUM_SLOTS];

    led_status_t  pending_status[$];
    int           err_count;
    int           status_index;
    int           cycle_count;
    bit           no_gaps;

    led_blink_pattern_controller_unit #(
        .SLOT_COUNT    (NUM_SLOTS),
        .INTERVAL_BITS (16)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .pin            (pin),
        .stop_request   (stop_request),
        .blink_interval (blink_interval),
        .pause_interval (pause_interval),
        .blink_count    (blink_count),
        .repeat_burst   (repeat_burst),
        .done           (done),
        .accepted       (accepted),
        .slot_used      (slot_used),
        .led_levels     (led_levels),
        .running_mask   (running_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [FIELD_W-1:0] clamp_interval(input logic [FIELD_W-1:0] v);
        return (v == '0) ? FIELD_W'(1) : v;
    endfunction

    function automatic void advance_slot(input int s);
        if (!led_running[s])
            return;
        if (led_remaining[s] != '0)
            led_remaining[s] = led_remaining[s] - 1'b1;
        if (led_remaining[s] != '0)
            return;
        led_lit[s] = ~led_lit[s];
        if (led_count[s] != '0)
        begin
            led_flips[s] = led_flips[s] + 1'b1;
            if (led_flips[s] >= {led_count[s], 1'b0})
            begin
                if (led_repeat[s])
                begin
                    led_flips[s]     = '0;
                    led_remaining[s] = led_pause[s];
                end
                else
                begin
                    led_lit[s]     = 1'b0;
                    led_running[s] = 1'b0;
                end
                return;
            end
        end
        led_remaining[s] = led_interval[s];
    endfunction

    function automatic led_status_t apply_item(input led_cmd_t c);
        led_status_t r;
        int          pick;
        r.accepted  = 1'b1;
        r.slot_used = NO_SLOT;
        pick        = -1;
        if (c.kind == OP_TICK)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
                advance_slot(s);
        end
        else
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
                if (pick < 0 && (led_pin[s] == c.pin || !led_allocated[s]))
                    pick = s;
            if (pick < 0)
                r.accepted = 1'b0;
            else
            begin
                r.slot_used = OUT_SLOT_W'(pick);
                if (c.kind == OP_STOP)
                begin
                    // a stop on a never-used slot leaves it untouched
                    if (led_allocated[pick])
                    begin
                        led_running[pick] = 1'b0;
                        led_lit[pick]     = 1'b0;
                    end
                end
                else
                begin
                    led_pin[pick]       = c.pin;
                    led_allocated[pick] = 1'b1;
                    led_interval[pick]  = clamp_interval(c.interval);
                    led_pause[pick]     = clamp_interval(c.pause);
                    led_count[pick]     = c.count;
                    led_repeat[pick]    = c.rep;
                    led_flips[pick]     = '0;
                    led_lit[pick]       = 1'b0;
                    led_remaining[pick] = clamp_interval(c.interval);
                    led_running[pick]   = 1'b1;
                end
            end
        end
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            r.led_levels[s]   = led_lit[s];
            r.running_mask[s] = led_running[s];
        end
        return r;
    endfunction

    function automatic led_cmd_t tick_cmd();
        led_cmd_t c;
        c.kind     = OP_TICK;
        c.pin      = PIN_W'($urandom);
        c.interval = FIELD_W'($urandom);
        c.pause    = FIELD_W'($urandom);
        c.count    = CNT_W'($urandom);
        c.rep      = 1'($urandom);
        return c;
    endfunction

    function automatic led_cmd_t load_cmd(input logic [PIN_W-1:0] p,
                                          input logic [FIELD_W-1:0] iv,
                                          input logic [FIELD_W-1:0] pv,
                                          input logic [CNT_W-1:0] cnt,
                                          input logic rep);
        led_cmd_t c;
        c.kind     = OP_LOAD;
        c.pin      = p;
        c.interval = iv;
        c.pause    = pv;
        c.count    = cnt;
        c.rep      = rep;
        return c;
    endfunction

    function automatic led_cmd_t stop_cmd(input logic [PIN_W-1:0] p);
        led_cmd_t c;
        c      = tick_cmd();
        c.kind = OP_STOP;
        c.pin  = p;
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // expects to be called just after a falling edge; leaves start high
    task automatic send_item(input led_cmd_t c);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          <= 1'b1;
        operation      <= (c.kind != OP_TICK);
        pin            <= c.pin;
        stop_request   <= (c.kind == OP_STOP);
        blink_interval <= c.interval;
        pause_interval <= c.pause;
        blink_count    <= c.count;
        repeat_burst   <= c.rep;
        do
            @(posedge clk);
        while (busy);
        pending_status.push_back(apply_item(c));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            led_status_t want;
            if (pending_status.size() == 0)
                report_mismatch($sformatf("result %0d with no item pending", status_index));
            else
            begin
                want = pending_status.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch($sformatf("result %0d accepted %b, want %b",
                                              status_index, accepted, want.accepted));
                if (slot_used !== want.slot_used)
                    report_mismatch($sformatf("result %0d slot_used %0d, want %0d",
                                              status_index, slot_used, want.slot_used));
                if (led_levels !== want.led_levels)
                    report_mismatch($sformatf("result %0d led_levels %b, want %b",
                                              status_index, led_levels, want.led_levels));
                if (running_mask !== want.running_mask)
                    report_mismatch($sformatf("result %0d running_mask %b, want %b",
                                              status_index, running_mask,
                                              want.running_mask));
            end
            status_index++;
        end
    end

    task automatic test_after_reset();
        send_item(tick_cmd());
    endtask

    task automatic test_stop_unused();
        // slot 0 is free, so both stops land there and change nothing
        send_item(stop_cmd(6'd63));
        send_item(stop_cmd(6'd0));
    endtask

    task automatic test_load_extremes();
        // zero interval and pause, endless count
        send_item(load_cmd(6'd63, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(load_cmd(6'd42, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(load_cmd(6'd21, 16'd1, 16'd2, 16'd1, 1'b1));
    endtask

    task automatic test_no_free_slot();
        send_item(load_cmd(6'd0, 16'd1, 16'd1, 16'd1, 1'b0));
        send_item(stop_cmd(6'd7));
    endtask

    task automatic test_burst_and_repeat();
        repeat (6) send_item(tick_cmd());
        // overwrite a running slot with a single burst that then stops
        send_item(load_cmd(6'd21, 16'd2, 16'd0, 16'd1, 1'b0));
        repeat (5) send_item(tick_cmd());
    endtask

    task automatic test_stop_used();
        send_item(stop_cmd(6'd63));
        send_item(stop_cmd(6'd42));
        send_item(tick_cmd());
        send_item(load_cmd(6'd63, 16'd1, 16'd0, 16'd2, 1'b1));
    endtask

    task automatic test_random_traffic(input int n_items);
        led_cmd_t     c;
        int unsigned  roll;
        logic [PIN_W-1:0] p;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            p    = led_pin[$urandom_range(0, NUM_SLOTS - 1)];
            if (roll < 62)
                c = tick_cmd();
            else if (roll < 82)
            begin
                c = load_cmd(p, FIELD_W'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 4)),
                             CNT_W'($urandom_range(0, 3)), 1'($urandom));
                // now and then a full-range load
                if ($urandom_range(0, 9) == 0)
                begin
                    c.interval = FIELD_W'($urandom);
                    c.pause    = FIELD_W'($urandom);
                    c.count    = CNT_W'($urandom);
                end
            end
            else if (roll < 88)
                c = stop_cmd(p);
            else
            begin
                // unknown pins are mostly rejected since every slot is taken
                c      = tick_cmd();
                c.kind = ($urandom_range(0, 1) == 1) ? OP_LOAD : OP_STOP;
            end
            send_item(c);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_idle_drain();
        wait_for_results();
        send_item(tick_cmd());
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        operation      = 1'b0;
        pin            = '0;
        stop_request   = 1'b0;
        blink_interval = '0;
        pause_interval = '0;
        blink_count    = '0;
        repeat_burst   = 1'b0;
        err_count      = 0;
        status_index   = 0;
        no_gaps        = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            led_pin[s]       = '0;
            led_allocated[s] = 1'b0;
            led_running[s]   = 1'b0;
            led_lit[s]       = 1'b0;
            led_interval[s]  = '0;
            led_pause[s]     = '0;
            led_count[s]     = '0;
            led_repeat[s]    = 1'b0;
            led_flips[s]     = '0;
            led_remaining[s] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_after_reset();
        test_stop_unused();
        test_load_extremes();
        test_no_free_slot();
        test_burst_and_repeat();
        test_stop_used();
        test_random_traffic(525);
        test_idle_drain();
        test_random_traffic(525);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
